// ===== hdl/mexn_pkg.sv =====
// mexn_pkg: shared types and codes for the mutual-exclusion node
// no dependencies; compiled before the interfaces and the top level

package mexn_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned NODE_W = 3;
  localparam int unsigned DIR_W  = 2;
  localparam int unsigned NODE_IDS = 1 << NODE_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CNT_CFG_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT     = 2'd2;

  localparam logic [CNT_CFG_W-1:0] NODE_COUNT_RST = 4'd2;

  // event codes
  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LEAVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEER    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd3;

  // message kinds
  localparam logic MSG_BROADCAST = 1'b0;
  localparam logic MSG_ACK       = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN_RD,
    ST_DRAIN_WR
  } state_e;

endpackage

// ===== hdl/mexn_if.sv =====
// mexn_in_if / mexn_out_if: valid/ready channels for events and messages
// depends on mexn_pkg

interface mexn_in_if;
  import mexn_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] peer_node;
  logic [DIR_W-1:0]  peer_direction;
  logic [DIR_W-1:0]  own_direction;

  modport source (
    output valid, func, peer_node, peer_direction, own_direction,
    input  ready
  );

  modport sink (
    input  valid, func, peer_node, peer_direction, own_direction,
    output ready
  );
endinterface

interface mexn_out_if;
  import mexn_pkg::*;

  logic              valid;
  logic              ready;
  logic              message_kind;
  logic [NODE_W-1:0] target_node;
  logic [DIR_W-1:0]  message_direction;
  logic              last_message;

  modport source (
    output valid, message_kind, target_node, message_direction, last_message,
    input  ready
  );

  modport sink (
    input  valid, message_kind, target_node, message_direction, last_message,
    output ready
  );
endinterface

// ===== hdl/mutual_exclusion_node_top.sv =====
// mutual_exclusion_node_top: one node of a request/acknowledge mutual-exclusion scheme
// depends on mexn_pkg and mexn_if (mexn_in_if, mexn_out_if)
// one event at a time: accept, a decision state, then for a drain a read state and
// one acknowledgement per cycle from the deferred memory while the output is not
// stalled; ready only when idle
// async active-low reset clears control state; the deferred memory needs no clearing

module mutual_exclusion_node_top #(
  parameter int unsigned MAX_NODES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mexn_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mexn_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  mexn_in_if.sink                          req_i,
  mexn_out_if.source                       res_o
);
  import mexn_pkg::*;

  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = $clog2(MAX_NODES);

  state_e state_q, state_d;

  // configuration
  logic                 dir_mode_q;
  logic [NODE_W-1:0]    own_node_q;
  logic [CNT_CFG_W-1:0] node_count_q;

  // latched event
  logic [FUNC_W-1:0] func_q;
  logic [NODE_W-1:0] peer_q;
  logic [DIR_W-1:0]  pdir_q;
  logic [DIR_W-1:0]  odir_q;

  // protocol state
  logic [CW-1:0]        count_q, count_d;
  logic [NODE_IDS-1:0]  marks_q, marks_d;
  logic [MAX_NODES-1:0] awaited_q, awaited_d;
  logic                 in_sec_q, in_sec_d;
  logic                 waiting_q, waiting_d;
  logic [CW-1:0]        idx_q, idx_d;

  // deferred memory
  logic [NODE_W-1:0] mem [MAX_NODES];
  logic [NODE_W-1:0] rd_data_q;
  logic              mem_we;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  // output register
  logic              out_valid_q;
  logic              out_kind_q;
  logic [NODE_W-1:0] out_target_q;
  logic [DIR_W-1:0]  out_dir_q;
  logic              out_last_q;
  logic              load;
  logic              load_kind;
  logic [NODE_W-1:0] load_target;
  logic [DIR_W-1:0]  load_dir;
  logic              load_last;

  // decisions on the latched event
  logic                 idle_node;
  logic                 imm_ack;
  logic                 can_queue;
  logic [CW-1:0]        count_after;
  logic                 drain_go;
  logic                 drain_start;
  logic                 out_free;
  logic [CW-1:0]        idx_plus1;
  logic                 drain_last;
  logic [MAX_NODES-1:0] req_mask;
  logic [MAX_NODES-1:0] awaited_clr;

  assign idle_node   = !in_sec_q && !waiting_q;
  assign imm_ack     = (func_q == FUNC_PEER) && dir_mode_q && (peer_q != own_node_q) &&
                       (count_q == '0) && (odir_q == pdir_q);
  assign can_queue   = (func_q == FUNC_PEER) && !imm_ack && !marks_q[peer_q] &&
                       (count_q != CW'(MAX_NODES));
  assign count_after = can_queue ? count_q + CW'(1) : count_q;
  assign drain_go    = (func_q == FUNC_LEAVE) ||
                       ((func_q == FUNC_PEER) && !imm_ack &&
                        (idle_node || ((peer_q == own_node_q) && waiting_q)));
  assign drain_start = drain_go && (count_after != '0);
  assign out_free    = !out_valid_q || res_o.ready;
  assign idx_plus1   = idx_q + CW'(1);
  assign drain_last  = (idx_plus1 == count_q);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      req_mask[i]    = (i < int'(node_count_q));
      awaited_clr[i] = awaited_q[i] && (i != int'(peer_q));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = drain_start ? ST_DRAIN_RD : ST_IDLE;
      end
      ST_DRAIN_RD: begin
        state_d = ST_DRAIN_WR;
      end
      ST_DRAIN_WR: begin
        if (out_free && drain_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs and state updates
  always_comb begin
    count_d     = count_q;
    marks_d     = marks_q;
    awaited_d   = awaited_q;
    in_sec_d    = in_sec_q;
    waiting_d   = waiting_q;
    idx_d       = idx_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q[AW-1:0];
    load        = 1'b0;
    load_kind   = MSG_ACK;
    load_target = peer_q;
    load_dir    = '0;
    load_last   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        if (out_free) begin
          idx_d = '0;
          case (func_q)
            FUNC_REQUEST: begin
              if (idle_node) begin
                waiting_d   = 1'b1;
                awaited_d   = req_mask;
                load        = 1'b1;
                load_kind   = MSG_BROADCAST;
                load_target = own_node_q;
                load_dir    = odir_q;
              end
            end
            FUNC_LEAVE: begin
              in_sec_d = 1'b0;
            end
            FUNC_PEER: begin
              if (imm_ack) load = 1'b1;
              if (can_queue) begin
                mem_we  = 1'b1;
                count_d = count_after;
                marks_d = marks_q | (NODE_IDS'(1) << peer_q);
              end
            end
            default: begin
              awaited_d = awaited_clr;
              if ((awaited_clr == '0) && waiting_q) begin
                waiting_d = 1'b0;
                in_sec_d  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_DRAIN_RD: begin
        rd_en = 1'b1;
      end
      ST_DRAIN_WR: begin
        if (out_free) begin
          load        = 1'b1;
          load_target = rd_data_q;
          load_last   = drain_last;
          if (drain_last) begin
            count_d = '0;
            marks_d = '0;
          end else begin
            idx_d   = idx_plus1;
            rd_en   = 1'b1;
            rd_addr = idx_plus1[AW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dir_mode_q   <= 1'b0;
      own_node_q   <= '0;
      node_count_q <= NODE_COUNT_RST;
      count_q      <= '0;
      marks_q      <= '0;
      awaited_q    <= '0;
      in_sec_q     <= 1'b0;
      waiting_q    <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      marks_q   <= marks_d;
      awaited_q <= awaited_d;
      in_sec_q  <= in_sec_d;
      waiting_q <= waiting_d;
      idx_q     <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DIRECTION_MODE: dir_mode_q   <= cfg_data_i[0];
          CFG_OWN_NODE:       own_node_q   <= cfg_data_i[NODE_W-1:0];
          CFG_NODE_COUNT:     node_count_q <= cfg_data_i[CNT_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // event and message payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q <= req_i.func;
      peer_q <= req_i.peer_node;
      pdir_q <= req_i.peer_direction;
      odir_q <= req_i.own_direction;
    end
    if (load) begin
      out_kind_q   <= load_kind;
      out_target_q <= load_target;
      out_dir_q    <= load_dir;
      out_last_q   <= load_last;
    end
  end

  // deferred list
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q[AW-1:0]] <= peer_q;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.message_kind      = out_kind_q;
  assign res_o.target_node       = out_target_q;
  assign res_o.message_direction = out_dir_q;
  assign res_o.last_message      = out_last_q;

  a_count_matches_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(marks_q) == int'(count_q))
    else $error("deferred count and marks disagree");

  a_not_waiting_in_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_sec_q && waiting_q))
    else $error("waiting while in the section");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN_WR) |-> (count_q != '0) && (idx_q < count_q))
    else $error("drain beyond deferred entries");

  a_leave_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN_WR && out_free && drain_last) |=> (count_q == '0))
    else $error("deferred list not emptied after drain");

endmodule

// ===== bench/tb_mutual_exclusion_node_top.sv =====
`timescale 1ns / 1ps
// tb_mutual_exclusion_node_top: self-checking bench for the mutual-exclusion node
// depends on mexn_pkg, mexn_if and mutual_exclusion_node_top

module tb_mutual_exclusion_node_top;
  import mexn_pkg::*;

  localparam int unsigned NODES       = 8;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] target;
    logic [DIR_W-1:0]  dir;
    logic              last;
  } message_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mexn_in_if  req_if ();
  mexn_out_if res_if ();

  mutual_exclusion_node_top #(.MAX_NODES(NODES)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the node
  logic                 mode_q;
  logic [NODE_W-1:0]    own_q;
  logic [CNT_CFG_W-1:0] count_q;
  logic [NODE_W-1:0]    deferred_ids [NODES];
  int unsigned          deferred_n;
  logic [NODES-1:0]     deferred_seen;
  logic [NODES-1:0]     acks_owed;
  logic                 in_section;
  logic                 waiting;

  message_t    new_msgs [$];
  message_t    expected_msgs [$];
  int unsigned errors;
  int unsigned effective_events;
  int unsigned cycle_count;
  int unsigned ready_hold;
  bit          idle_on;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic void queue_message(input logic kind, input logic [NODE_W-1:0] target,
                                        input logic [DIR_W-1:0] dir);
    message_t m;
    m.kind   = kind;
    m.target = target;
    m.dir    = dir;
    m.last   = 1'b0;
    new_msgs = {new_msgs, m};
  endfunction

  function automatic void drain_deferred();
    for (int i = 0; i < deferred_n; i++) queue_message(MSG_ACK, deferred_ids[i], '0);
    deferred_n    = 0;
    deferred_seen = '0;
  endfunction

  // returns 1 when the event leaves the node untouched
  function automatic bit predict_messages(input logic [FUNC_W-1:0] func,
                                          input logic [NODE_W-1:0] peer,
                                          input logic [DIR_W-1:0] pdir,
                                          input logic [DIR_W-1:0] odir);
    logic [21:0] snap;
    int unsigned n;
    snap = {deferred_n[3:0], deferred_seen, acks_owed, in_section, waiting};
    case (func)
      FUNC_REQUEST: begin
        if (!in_section && !waiting) begin
          n = (count_q > NODES) ? NODES : count_q;
          waiting   = 1'b1;
          acks_owed = '0;
          for (int i = 0; i < n; i++) acks_owed[i] = 1'b1;
          queue_message(MSG_BROADCAST, own_q, odir);
        end
      end
      FUNC_LEAVE: begin
        in_section = 1'b0;
        drain_deferred();
      end
      FUNC_PEER: begin
        if (mode_q && peer != own_q && deferred_n == 0 && odir == pdir) begin
          queue_message(MSG_ACK, peer, '0);
        end else begin
          if (!deferred_seen[peer] && deferred_n < NODES) begin
            deferred_ids[deferred_n] = peer;
            deferred_n++;
            deferred_seen[peer] = 1'b1;
          end
          if ((!in_section && !waiting) || (peer == own_q && waiting)) drain_deferred();
        end
      end
      default: begin
        acks_owed[peer] = 1'b0;
        if (acks_owed == '0 && waiting) begin
          waiting    = 1'b0;
          in_section = 1'b1;
        end
      end
    endcase
    if (new_msgs.size() == 0)
      return snap == {deferred_n[3:0], deferred_seen, acks_owed, in_section, waiting};
    new_msgs[new_msgs.size() - 1].last = 1'b1;
    expected_msgs = {expected_msgs, new_msgs};
    new_msgs.delete();
    return 1'b0;
  endfunction

  // one event transaction; called and returns at a falling edge
  task automatic send_event(input logic [FUNC_W-1:0] func, input logic [NODE_W-1:0] peer,
                            input logic [DIR_W-1:0] pdir, input logic [DIR_W-1:0] odir);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid          = 1'b1;
    req_if.func           = func;
    req_if.peer_node      = peer;
    req_if.peer_direction = pdir;
    req_if.own_direction  = odir;
    do @(posedge clk_i); while (!req_if.ready);
    if (!predict_messages(func, peer, pdir, odir)) effective_events++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    case (idx)
      CFG_DIRECTION_MODE: mode_q = value[0];
      CFG_OWN_NODE:       own_q = value[NODE_W-1:0];
      CFG_NODE_COUNT:     count_q = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic settle();
    req_if.valid = 1'b0;
    while (expected_msgs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic apply_config(input logic mode, input logic [NODE_W-1:0] own,
                              input logic [CNT_CFG_W-1:0] count);
    settle();
    write_reg(CFG_DIRECTION_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_OWN_NODE, CFG_DATA_W'(own));
    write_reg(CFG_NODE_COUNT, count);
  endtask

  task automatic random_peer_request();
    logic [DIR_W-1:0] odir;
    logic [DIR_W-1:0] pdir;
    odir = DIR_W'($urandom_range(0, 3));
    pdir = (mode_q && $urandom_range(0, 1)) ? odir : DIR_W'($urandom_range(0, 3));
    send_event(FUNC_PEER, NODE_W'($urandom_range(0, 7)), pdir, odir);
  endtask

  task automatic random_event();
    send_event(FUNC_W'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 7)),
               DIR_W'($urandom_range(0, 3)), DIR_W'($urandom_range(0, 3)));
  endtask

  // request, acknowledgements in shuffled order with peer traffic, then usually leave
  task automatic random_round();
    int unsigned n;
    int unsigned j;
    int unsigned t;
    int unsigned order [NODES];
    n = (count_q > NODES) ? NODES : count_q;
    send_event(FUNC_REQUEST, NODE_W'($urandom_range(0, 7)), DIR_W'($urandom_range(0, 3)),
               DIR_W'($urandom_range(0, 3)));
    repeat ($urandom_range(0, 3)) random_peer_request();
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) random_peer_request();
      if ($urandom_range(0, 9) == 0)
        send_event(FUNC_ACK, NODE_W'($urandom_range(0, 7)), DIR_W'($urandom_range(0, 3)),
                   DIR_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 19) != 0)
        send_event(FUNC_ACK, order[i][NODE_W-1:0], DIR_W'($urandom_range(0, 3)),
                   DIR_W'($urandom_range(0, 3)));
    end
    if (n == 0)
      send_event(FUNC_ACK, NODE_W'($urandom_range(0, 7)), DIR_W'($urandom_range(0, 3)),
                 DIR_W'($urandom_range(0, 3)));
    repeat ($urandom_range(0, 4)) random_peer_request();
    if ($urandom_range(0, 9) != 0)
      send_event(FUNC_LEAVE, NODE_W'($urandom_range(0, 7)), DIR_W'($urandom_range(0, 3)),
                 DIR_W'($urandom_range(0, 3)));
  endtask

  task automatic run_random_phase(input logic mode, input logic [NODE_W-1:0] own,
                                  input logic [CNT_CFG_W-1:0] count,
                                  input int unsigned goal, input bit calm);
    apply_config(mode, own, count);
    idle_on = !calm;
    effective_events = 0;
    while (effective_events < goal) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) random_event();
      else random_round();
    end
    idle_on = 1'b1;
  endtask

  // reset settings: own node 0, two nodes awaited, plain deferral
  task automatic test_reset_config();
    send_event(FUNC_PEER, 3'd7, 2'd3, 2'd3);
    send_event(FUNC_REQUEST, 3'd0, 2'd0, 2'd3);
    send_event(FUNC_REQUEST, 3'd0, 2'd0, 2'd1);
    send_event(FUNC_PEER, 3'd5, 2'd1, 2'd0);
    send_event(FUNC_PEER, 3'd5, 2'd2, 2'd0);
    send_event(FUNC_ACK, 3'd1, 2'd0, 2'd0);
    send_event(FUNC_ACK, 3'd0, 2'd0, 2'd0);
    send_event(FUNC_LEAVE, 3'd0, 2'd0, 2'd0);
  endtask

  task automatic test_full_deferred_list();
    send_event(FUNC_REQUEST, 3'd0, 2'd0, 2'd2);
    send_event(FUNC_PEER, 3'd0, 2'd1, 2'd2);
    send_event(FUNC_PEER, 3'd1, 2'd0, 2'd2);
    send_event(FUNC_PEER, 3'd3, 2'd1, 2'd2);
    send_event(FUNC_PEER, 3'd4, 2'd2, 2'd2);
    send_event(FUNC_PEER, 3'd5, 2'd3, 2'd2);
    send_event(FUNC_PEER, 3'd6, 2'd0, 2'd2);
    send_event(FUNC_PEER, 3'd7, 2'd1, 2'd2);
    send_event(FUNC_ACK, 3'd0, 2'd0, 2'd0);
    send_event(FUNC_ACK, 3'd1, 2'd0, 2'd0);
    send_event(FUNC_PEER, 3'd0, 2'd3, 2'd1);
    send_event(FUNC_PEER, 3'd2, 2'd3, 2'd1);
    send_event(FUNC_PEER, 3'd4, 2'd3, 2'd1);
    send_event(FUNC_LEAVE, 3'd0, 2'd0, 2'd0);
  endtask

  // same-direction peers, own node as peer, nothing awaited, stray acknowledgement
  task automatic test_direction_mode();
    apply_config(1'b1, 3'd7, 4'd0);
    send_event(FUNC_PEER, 3'd3, 2'd1, 2'd1);
    send_event(FUNC_PEER, 3'd7, 2'd1, 2'd1);
    send_event(FUNC_REQUEST, 3'd0, 2'd0, 2'd2);
    send_event(FUNC_ACK, 3'd5, 2'd0, 2'd0);
    send_event(FUNC_PEER, 3'd1, 2'd0, 2'd0);
    send_event(FUNC_LEAVE, 3'd0, 2'd0, 2'd0);
  endtask

  task automatic test_random_phases();
    run_random_phase(1'b0, 3'd3, 4'd8, 45, 1'b0);
    run_random_phase(1'b1, 3'd5, 4'd15, 40, 1'b0);
    run_random_phase(1'b0, 3'd7, 4'd1, 35, 1'b1);
    run_random_phase(1'b1, 3'd0, 4'd0, 35, 1'b0);
    run_random_phase(1'($urandom_range(0, 1)), NODE_W'($urandom_range(0, 7)),
                     CNT_CFG_W'($urandom_range(0, 15)), 45, 1'b0);
    run_random_phase(1'b1, NODE_W'($urandom_range(0, 7)), 4'd4, 50, 1'b0);
  endtask

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      res_if.ready = 1'b0;
      ready_hold--;
    end else begin
      res_if.ready = 1'b1;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_messages
    message_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_msgs.size() == 0) begin
        $error("unexpected message kind %0d target %0d", res_if.message_kind,
               res_if.target_node);
        errors++;
      end else begin
        want = expected_msgs.pop_front();
        if (res_if.message_kind !== want.kind) begin
          $error("message_kind expected %0d got %0d", want.kind, res_if.message_kind);
          errors++;
        end
        if (res_if.target_node !== want.target) begin
          $error("target_node expected %0d got %0d", want.target, res_if.target_node);
          errors++;
        end
        if (res_if.message_direction !== want.dir) begin
          $error("message_direction expected %0d got %0d", want.dir,
                 res_if.message_direction);
          errors++;
        end
        if (res_if.last_message !== want.last) begin
          $error("last_message expected %0d got %0d", want.last, res_if.last_message);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = '0;
    cfg_data_i            = '0;
    req_if.valid          = 1'b0;
    req_if.func           = '0;
    req_if.peer_node      = '0;
    req_if.peer_direction = '0;
    req_if.own_direction  = '0;
    res_if.ready          = 1'b0;
    ready_hold            = 0;
    idle_on               = 1'b1;
    errors                = 0;
    cycle_count           = 0;
    effective_events      = 0;
    mode_q                = 1'b0;
    own_q                 = '0;
    count_q               = NODE_COUNT_RST;
    deferred_n            = 0;
    deferred_seen         = '0;
    acks_owed             = '0;
    in_section            = 1'b0;
    waiting               = 1'b0;
    foreach (deferred_ids[i]) deferred_ids[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_full_deferred_list();
    test_direction_mode();
    test_random_phases();

    settle();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
